// ===== rtl/core/bcs_pkg.sv =====
// Shared types, magic signature table and verdict logic for the content sniffer.
`timescale 1ns / 1ps

package bcs_pkg;

  localparam int unsigned HEAD_DEPTH = 6;
  localparam int unsigned SIG_COUNT  = 21;
  localparam int unsigned LEN_W      = 14;

  // Reason codes carried on the result channel
  typedef enum logic [1:0] {
    REASON_TEXT    = 2'd0,
    REASON_MAGIC   = 2'd1,
    REASON_ZEROS   = 2'd2,
    REASON_CONTROL = 2'd3
  } bcs_reason_e;

  // Leading bytes of a sample and how many of them are filled
  typedef struct packed {
    logic [0:HEAD_DEPTH-1][7:0] bytes;
    logic [2:0]                 fill;
  } bcs_head_t;

  // One magic signature: length in bytes, then the bytes, first byte leftmost
  typedef struct packed {
    logic [2:0]                 len;
    logic [0:HEAD_DEPTH-1][7:0] bytes;
  } bcs_magic_t;

  localparam bcs_magic_t MAGIC_TABLE [SIG_COUNT] = '{
    '{3'd4, 48'h8950_4E47_0000},  // PNG
    '{3'd3, 48'hFFD8_FF00_0000},  // JPEG
    '{3'd6, 48'h4749_4638_3761},  // GIF87a
    '{3'd6, 48'h4749_4638_3961},  // GIF89a
    '{3'd4, 48'h5249_4646_0000},  // RIFF
    '{3'd4, 48'h4F67_6753_0000},  // Ogg
    '{3'd4, 48'h2550_4446_0000},  // PDF
    '{3'd4, 48'h504B_0304_0000},  // zip
    '{3'd2, 48'h1F8B_0000_0000},  // gzip
    '{3'd3, 48'h425A_6800_0000},  // bzip2
    '{3'd4, 48'h5261_7221_0000},  // rar
    '{3'd4, 48'h0000_0100_0000},  // icon
    '{3'd4, 48'h0000_0200_0000},  // cursor
    '{3'd2, 48'h424D_0000_0000},  // bitmap
    '{3'd4, 48'h4949_2A00_0000},  // TIFF, little endian
    '{3'd4, 48'h4D4D_002A_0000},  // TIFF, big endian
    '{3'd4, 48'hCAFE_BABE_0000},  // class file / fat binary
    '{3'd4, 48'hFEED_FACE_0000},  // Mach-O 32
    '{3'd4, 48'hFEED_FACF_0000},  // Mach-O 64
    '{3'd4, 48'h7F45_4C46_0000},  // ELF
    '{3'd2, 48'h4D5A_0000_0000}   // DOS executable
  };

  // True when the filled head starts with any signature; a signature longer
  // than the fill never matches.
  function automatic logic magic_hit(input bcs_head_t head);
    logic hit;
    logic same;
    hit = 1'b0;
    for (int s = 0; s < SIG_COUNT; s++) begin
      same = (head.fill >= MAGIC_TABLE[s].len);
      for (int k = 0; k < HEAD_DEPTH; k++) begin
        if (3'(k) < MAGIC_TABLE[s].len && head.bytes[k] != MAGIC_TABLE[s].bytes[k]) begin
          same = 1'b0;
        end
      end
      hit = hit | same;
    end
    return hit;
  endfunction

endpackage

// ===== rtl/core/bcs_accum.sv =====
// Per-sample statistics: head store, byte/zero/control counters and summary register.
`timescale 1ns / 1ps

module bcs_accum
  import bcs_pkg::*;
#(
  parameter int unsigned SAMPLE_MAX = 8192,
  parameter int unsigned CNT_W      = $clog2(SAMPLE_MAX + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             has_byte_i,
  input  logic             last_i,
  output logic             sum_valid_o,
  input  logic             sum_ready_i,
  output bcs_head_t        sum_head_o,
  output logic [CNT_W-1:0] sum_bytes_o,
  output logic [CNT_W-1:0] sum_zeros_o,
  output logic [CNT_W-1:0] sum_ctrl_o
);

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(SAMPLE_MAX);

  logic [0:HEAD_DEPTH-1][7:0] head_q, head_d;
  logic [CNT_W-1:0]           bytes_q, bytes_d;
  logic [CNT_W-1:0]           zeros_q, zeros_d;
  logic [CNT_W-1:0]           ctrl_q, ctrl_d;
  logic                       sum_valid_q;
  bcs_head_t                  sum_head_q;
  logic [CNT_W-1:0]           sum_bytes_q, sum_zeros_q, sum_ctrl_q;

  logic take, is_zero, is_ctrl, accept, sum_free;

  assign sum_free   = !sum_valid_q || sum_ready_i;
  assign in_ready_o = sum_free;
  assign accept     = in_valid_i && in_ready_o;

  assign take    = has_byte_i && (bytes_q < MAX_C);
  assign is_zero = (data_byte_i == 8'd0);
  assign is_ctrl = ((data_byte_i < 8'd32) && (data_byte_i != 8'd9) &&
                    (data_byte_i != 8'd10) && (data_byte_i != 8'd13)) ||
                   (data_byte_i == 8'd127);

  always_comb begin
    head_d  = head_q;
    bytes_d = bytes_q;
    zeros_d = zeros_q;
    ctrl_d  = ctrl_q;
    if (take) begin
      for (int k = 0; k < HEAD_DEPTH; k++) begin
        if (bytes_q == CNT_W'(k)) begin
          head_d[k] = data_byte_i;
        end
      end
      bytes_d = bytes_q + 1'b1;
      if (is_zero) begin
        zeros_d = zeros_q + 1'b1;
      end
      if (is_ctrl) begin
        ctrl_d = ctrl_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      bytes_q     <= '0;
      zeros_q     <= '0;
      ctrl_q      <= '0;
      sum_valid_q <= 1'b0;
    end else begin
      if (accept && last_i) begin
        head_q      <= '0;
        bytes_q     <= '0;
        zeros_q     <= '0;
        ctrl_q      <= '0;
        sum_valid_q <= 1'b1;
      end else begin
        if (accept) begin
          head_q  <= head_d;
          bytes_q <= bytes_d;
          zeros_q <= zeros_d;
          ctrl_q  <= ctrl_d;
        end
        if (sum_ready_i) begin
          sum_valid_q <= 1'b0;
        end
      end
    end
  end

  // Summary payload: load on the closing item of a sample
  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      sum_head_q.bytes <= head_d;
      sum_head_q.fill  <= (bytes_d >= CNT_W'(HEAD_DEPTH)) ? 3'(HEAD_DEPTH) : bytes_d[2:0];
      sum_bytes_q      <= bytes_d;
      sum_zeros_q      <= zeros_d;
      sum_ctrl_q       <= ctrl_d;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_head_o  = sum_head_q;
  assign sum_bytes_o = sum_bytes_q;
  assign sum_zeros_o = sum_zeros_q;
  assign sum_ctrl_o  = sum_ctrl_q;

endmodule

// ===== rtl/core/bcs_judge.sv =====
// Verdict logic on a sample summary, with the result register.
`timescale 1ns / 1ps

module bcs_judge
  import bcs_pkg::*;
#(
  parameter int unsigned CNT_W = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             sum_valid_i,
  output logic             sum_ready_o,
  input  bcs_head_t        sum_head_i,
  input  logic [CNT_W-1:0] sum_bytes_i,
  input  logic [CNT_W-1:0] sum_zeros_i,
  input  logic [CNT_W-1:0] sum_ctrl_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             is_binary_o,
  output logic [1:0]       reason_o,
  output logic [LEN_W-1:0] sample_length_o
);

  localparam int unsigned CMP_W = CNT_W + 4;

  logic [CMP_W-1:0] bytes_x, zeros_x8, ctrl_x10;
  logic             hit, many_zeros, many_ctrl, load;
  bcs_reason_e      reason_d;

  logic             out_valid_q;
  logic             is_binary_q;
  bcs_reason_e      reason_q;
  logic [LEN_W-1:0] length_q;

  // zeros > floor(n/8)  <=>  8*zeros > n ; control > floor(n/10) <=> 10*control > n
  assign bytes_x    = CMP_W'(sum_bytes_i);
  assign zeros_x8   = CMP_W'(sum_zeros_i) << 3;
  assign ctrl_x10   = (CMP_W'(sum_ctrl_i) << 3) + (CMP_W'(sum_ctrl_i) << 1);
  assign hit        = magic_hit(sum_head_i);
  assign many_zeros = zeros_x8 > bytes_x;
  assign many_ctrl  = ctrl_x10 > bytes_x;

  always_comb begin
    if (hit) begin
      reason_d = REASON_MAGIC;
    end else if (many_zeros) begin
      reason_d = REASON_ZEROS;
    end else if (many_ctrl) begin
      reason_d = REASON_CONTROL;
    end else begin
      reason_d = REASON_TEXT;
    end
  end

  assign sum_ready_o = !out_valid_q || out_ready_i;
  assign load        = sum_valid_i && sum_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      is_binary_q <= (reason_d != REASON_TEXT);
      reason_q    <= reason_d;
      length_q    <= LEN_W'(sum_bytes_i);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_binary_o     = is_binary_q;
  assign reason_o        = reason_q;
  assign sample_length_o = length_q;

endmodule

// ===== rtl/core/binary_content_sniffer_core.sv =====
// Top level of the binary content sniffer: statistics stage feeding the verdict stage.
`timescale 1ns / 1ps

// Streams a sample in one byte per item and returns one verdict per sample.
// Items may follow back to back while in_ready_o is high; the
// item marked last closes the sample, its statistics are held in a summary
// register and the verdict is then loaded into the result register once that
// register is free. Items without a byte (has_byte_i low) are idle unless they
// carry last, in which case they close the sample with the bytes seen so
// far; a sample with no bytes is reported as text with length zero. Only the
// first SAMPLE_MAX bytes of a sample are counted. The sample is binary when
// its head matches one of the 21 fixed magic signatures (reason 1), else
// when zero bytes exceed one eighth of the length (reason 2), else when
// control bytes (below 32 except tab, LF and CR, plus 127) exceed one tenth
// of the length (reason 3). in_ready_o drops only while both the summary
// register and the result register hold results that have not been taken.
module binary_content_sniffer_core
  import bcs_pkg::*;
#(
  parameter int unsigned SAMPLE_MAX = 8192
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             has_byte_i,
  input  logic             last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             is_binary_o,
  output logic [1:0]       reason_o,
  output logic [LEN_W-1:0] sample_length_o
);

  // Counters must hold SAMPLE_MAX itself
  localparam int unsigned CNT_W = $clog2(SAMPLE_MAX + 1);

  logic             sum_valid, sum_ready;
  bcs_head_t        sum_head;
  logic [CNT_W-1:0] sum_bytes, sum_zeros, sum_ctrl;

  // Accumulate the per-sample statistics; hand a summary over on last
  bcs_accum #(
    .SAMPLE_MAX (SAMPLE_MAX),
    .CNT_W      (CNT_W)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .sum_head_o  (sum_head),
    .sum_bytes_o (sum_bytes),
    .sum_zeros_o (sum_zeros),
    .sum_ctrl_o  (sum_ctrl)
  );

  // Judge the summary and hold the verdict until it is taken
  bcs_judge #(
    .CNT_W (CNT_W)
  ) u_judge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sum_valid_i     (sum_valid),
    .sum_ready_o     (sum_ready),
    .sum_head_i      (sum_head),
    .sum_bytes_i     (sum_bytes),
    .sum_zeros_i     (sum_zeros),
    .sum_ctrl_i      (sum_ctrl),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_binary_o     (is_binary_o),
    .reason_o        (reason_o),
    .sample_length_o (sample_length_o)
  );

endmodule
